// ----- rtl/bfp_pkg.sv -----
// Package for the byte ring FIFO with peek: store geometry, request codes
// and the packed types that pass between the FIFO's modules and its ports.
// No dependencies.
package bfp_pkg;

  localparam int Depth  = 256;
  localparam int AddrW  = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);
  localparam int ByteW  = 8;
  localparam int SizeW  = 9;
  localparam int ReqW   = 3;

  typedef logic [ReqW-1:0] req_code_t;

  localparam req_code_t REQ_WRITE      = 3'd0;
  localparam req_code_t REQ_READ       = 3'd1;
  localparam req_code_t REQ_PEEK       = 3'd2;
  localparam req_code_t REQ_RESET_PEEK = 3'd3;
  localparam req_code_t REQ_DROP_PEEK  = 3'd4;
  localparam req_code_t REQ_INIT       = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] write_byte;
    logic       start_full;
  } bfp_in_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] data_byte;
    logic [8:0] stored_count;
    logic [8:0] peek_available;
    logic [8:0] peeked_number;
  } bfp_out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } bfp_ram_req_t;

endpackage

// ----- rtl/bfp_ram.sv -----
// Generic single-clock RAM: one write port and one read port, registered
// read data. No dependencies.
module bfp_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bfp_ctrl.sv -----
// Pointer and count unit of the byte ring FIFO: head, tail and peek cursors,
// held and peek counts, store access requests and registered result fields.
// Depends on bfp_pkg.
module bfp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  bfp_pkg::bfp_in_t      item,
  input  logic [8:0]            size_in_use,
  output bfp_pkg::bfp_ram_req_t ram_req,
  output logic                  res_valid,
  output logic                  res_from_ram,
  output bfp_pkg::bfp_out_t     res
);
  import bfp_pkg::*;

  logic [AddrW-1:0]  head_r, head_nxt;
  logic [AddrW-1:0]  tail_r, tail_nxt;
  logic [AddrW-1:0]  peek_r, peek_nxt;
  logic [CountW-1:0] held_r, held_nxt;
  logic [CountW-1:0] left_r, left_nxt;
  logic              ok_nxt;
  logic              from_ram_nxt;
  logic [CountW-1:0] ring_size;
  logic [AddrW-1:0]  head_adv, tail_adv, peek_adv;
  logic              valid_r;
  logic              from_ram_r;
  bfp_out_t          res_r;

  // Ring size clamped into 1..Depth.
  always_comb begin
    if (size_in_use == '0) begin
      ring_size = CountW'(1);
    end else if ({1'b0, size_in_use} > (SizeW + 1)'(Depth)) begin
      ring_size = CountW'(Depth);
    end else begin
      ring_size = CountW'(size_in_use);
    end
  end

  function automatic logic [AddrW-1:0] advance(input logic [AddrW-1:0] idx,
                                               input logic [CountW-1:0] size);
    logic [CountW-1:0] n;
    n = CountW'(idx) + CountW'(1);
    return (n >= size) ? '0 : n[AddrW-1:0];
  endfunction

  assign head_adv = advance(head_r, ring_size);
  assign tail_adv = advance(tail_r, ring_size);
  assign peek_adv = advance(peek_r, ring_size);

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    peek_nxt      = peek_r;
    held_nxt      = held_r;
    left_nxt      = left_r;
    ok_nxt        = 1'b0;
    from_ram_nxt  = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = tail_r;
    ram_req.wdata = item.write_byte;
    ram_req.re    = 1'b0;
    ram_req.raddr = head_r;
    if (accept) begin
      unique case (item.req_type)
        REQ_WRITE: begin
          if (held_r < ring_size) begin
            ram_req.we = 1'b1;
            tail_nxt   = tail_adv;
            held_nxt   = held_r + CountW'(1);
            left_nxt   = left_r + CountW'(1);
            ok_nxt     = 1'b1;
          end
        end
        REQ_READ: begin
          if (held_r != '0) begin
            ram_req.re   = 1'b1;
            from_ram_nxt = 1'b1;
            head_nxt     = head_adv;
            peek_nxt     = head_adv;
            held_nxt     = held_r - CountW'(1);
            left_nxt     = held_r - CountW'(1);
            ok_nxt       = 1'b1;
          end
        end
        REQ_PEEK: begin
          ram_req.raddr = peek_r;
          if (left_r != '0) begin
            ram_req.re   = 1'b1;
            from_ram_nxt = 1'b1;
            peek_nxt     = peek_adv;
            left_nxt     = left_r - CountW'(1);
            ok_nxt       = 1'b1;
          end
        end
        REQ_RESET_PEEK: begin
          left_nxt = held_r;
          peek_nxt = head_r;
          ok_nxt   = 1'b1;
        end
        REQ_DROP_PEEK: begin
          held_nxt = left_r;
          head_nxt = peek_r;
          ok_nxt   = 1'b1;
        end
        REQ_INIT: begin
          head_nxt = '0;
          tail_nxt = '0;
          peek_nxt = '0;
          held_nxt = item.start_full ? ring_size : '0;
          left_nxt = item.start_full ? ring_size : '0;
          ok_nxt   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      peek_r     <= '0;
      held_r     <= '0;
      left_r     <= '0;
      valid_r    <= 1'b0;
      from_ram_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      peek_r     <= peek_nxt;
      held_r     <= held_nxt;
      left_r     <= left_nxt;
      valid_r    <= accept;
      from_ram_r <= from_ram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r.ok             <= ok_nxt;
      res_r.data_byte      <= '0;
      res_r.stored_count   <= 9'(held_nxt);
      res_r.peek_available <= 9'(left_nxt);
      res_r.peeked_number  <= 9'(held_nxt - left_nxt);
    end
  end

  assign res_valid    = valid_r;
  assign res_from_ram = from_ram_r;
  assign res          = res_r;

endmodule

// ----- rtl/byte_ring_fifo_with_peek.sv -----
// Top level of the byte ring FIFO with peek cursor: size register, byte
// store RAM and pointer unit. Depends on bfp_pkg, bfp_ram and bfp_ctrl.
//
//   channel   ports                        transfer when
//   -------   --------------------------   ------------------------------
//   request   start, busy, in_item         start high and busy low
//   result    out_valid, out_item          out_valid high (one cycle only)
//   config    cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready high
//
// Every request yields exactly one result, shown for one cycle in the cycle
// after its request transfer. A new request can be taken every cycle while
// busy is low. Reset (rst_n low at a clock edge) clears the cursors and
// counts, sets the ring size to 256 and holds busy high for the first
// cycle after release. The receiver cannot stall results, so nothing in
// the block waits. Read data comes from the store's registered read port.
module byte_ring_fifo_with_peek (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bfp_pkg::bfp_in_t  in_item,
  output logic              out_valid,
  output bfp_pkg::bfp_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_data
);
  import bfp_pkg::*;

  logic         busy_r;
  logic [8:0]   size_r;
  logic         accept;
  bfp_ram_req_t ram_req;
  logic [7:0]   ram_rdata;
  logic         res_valid;
  logic         res_from_ram;
  bfp_out_t     res;

  // busy covers only the cycle in which the block leaves reset; afterward
  // a request transfer can happen on any clock edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // The ring size register is always writable; the user applies an init
  // after changing it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 9'(Depth);
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_data;
    end
  end

  bfp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .item         (in_item),
    .size_in_use  (size_r),
    .ram_req      (ram_req),
    .res_valid    (res_valid),
    .res_from_ram (res_from_ram),
    .res          (res)
  );

  // A write lands at the edge of its transfer, so a read of the same entry
  // in any later request already sees it without forwarding.
  bfp_ram #(
    .DATA_W (ByteW),
    .ADDR_W (AddrW)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // The data byte comes from the store only for a successful read or peek;
  // every other result carries zero there.
  always_comb begin
    out_item = res;
    if (res_from_ram) begin
      out_item.data_byte = ram_rdata;
    end
  end

  assign out_valid = res_valid;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for byte_ring_fifo_with_peek: directed and random
// request traffic checked against a behavioral model of the ring and cursors.
// Depends on bfp_pkg and the byte_ring_fifo_with_peek RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bfp_pkg::*;

  // Request codes that the block does not define; it must answer them with
  // ok low and leave its state alone.
  localparam req_code_t REQ_BAD_LO = 3'd6;
  localparam req_code_t REQ_BAD_HI = 3'd7;

  // The block sizes the ring from a 9-bit register but never beyond the store.
  localparam int unsigned StoreDepth = Depth;
  localparam int unsigned CycleLimit = 200000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  bfp_in_t    in_item   = '0;
  logic       out_valid;
  bfp_out_t   out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_data  = '0;

  always #2ns clk = ~clk;

  byte_ring_fifo_with_peek DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Model of the ring. The store contents are mirrored together with a flag
  // per entry that tells whether it was ever written, so that the stimulus
  // can steer clear of reading an entry whose contents are undefined.
  logic [7:0]  mirror_bytes [StoreDepth];
  bit          byte_written [StoreDepth];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  int unsigned peek_ptr;
  int unsigned held;
  int unsigned peek_rem;
  logic [8:0]  size_reg = 9'd256;

  // Results predicted for accepted requests, oldest first.
  bfp_out_t    pending_results [$];
  int          mismatches  = 0;
  int          idle_pct    = 0;
  int unsigned cycle_count = 0;

  // A cursor that steps to or past the end of the ring goes back to zero;
  // this also pulls a cursor that was left beyond a shrunken ring back in.
  function automatic int unsigned wrap_next(int unsigned idx, int unsigned len);
    return (idx + 1 >= len) ? 0 : idx + 1;
  endfunction

  // Applies one request to the model and returns the result the block owes.
  function automatic bfp_out_t next_fifo_result(bfp_in_t req);
    int unsigned len;
    bfp_out_t    res;
    // A size of zero means one entry; anything past the store means all of it.
    len = (size_reg == 0) ? 1 : (size_reg > StoreDepth) ? StoreDepth : size_reg;
    res = '0;
    case (req.req_type)
      REQ_WRITE: begin
        if (held < len) begin
          mirror_bytes[tail_ptr] = req.write_byte;
          byte_written[tail_ptr] = 1'b1;
          tail_ptr = wrap_next(tail_ptr, len);
          held++;
          peek_rem++;
          res.ok = 1'b1;
        end
      end
      REQ_READ: begin
        // A read also rewinds the peek cursor to the new head.
        if (held != 0) begin
          res.data_byte = mirror_bytes[head_ptr];
          head_ptr = wrap_next(head_ptr, len);
          held--;
          peek_rem = held;
          peek_ptr = head_ptr;
          res.ok = 1'b1;
        end
      end
      REQ_PEEK: begin
        if (peek_rem != 0) begin
          res.data_byte = mirror_bytes[peek_ptr];
          peek_ptr = wrap_next(peek_ptr, len);
          peek_rem--;
          res.ok = 1'b1;
        end
      end
      REQ_RESET_PEEK: begin
        peek_rem = held;
        peek_ptr = head_ptr;
        res.ok = 1'b1;
      end
      REQ_DROP_PEEK: begin
        // Everything already peeked leaves the FIFO at once.
        held = peek_rem;
        head_ptr = peek_ptr;
        res.ok = 1'b1;
      end
      REQ_INIT: begin
        // Init only moves the pointers; the store keeps its bytes.
        head_ptr = 0;
        tail_ptr = 0;
        peek_ptr = 0;
        held = req.start_full ? len : 0;
        peek_rem = held;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.stored_count   = 9'(held);
    res.peek_available = 9'(peek_rem);
    res.peeked_number  = 9'(held - peek_rem);
    return res;
  endfunction

  // Offers one request and waits for its transfer. The sender may first go
  // idle for a random number of cycles, as the current idling rate says.
  // Start is left high after the transfer so that back-to-back requests keep
  // it high without a gap.
  task automatic send_req(input req_code_t code, input logic [7:0] wbyte,
                          input logic full);
    bfp_in_t req;
    req = '{req_type: code, write_byte: wbyte, start_full: full};
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_item <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(next_fifo_result(req));
  endtask

  // Stops sending and waits until every predicted result has come back,
  // then lets a few more cycles pass for anything still inside the block.
  task automatic wait_results_drained(input int settle);
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Writes the ring size register while the block is idle.
  task automatic set_ring_size(input logic [8:0] value);
    wait_results_drained(2);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = value;
  endtask

  task automatic check_field(input string name, input logic [8:0] exp_val,
                             input logic [8:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Every strobed result is taken at the edge that ends its cycle and is
  // matched against the oldest prediction.
  always @(posedge clk) begin
    bfp_out_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("ok", 9'(exp_res.ok), 9'(out_item.ok));
        check_field("data_byte", 9'(exp_res.data_byte), 9'(out_item.data_byte));
        check_field("stored_count", exp_res.stored_count, out_item.stored_count);
        check_field("peek_available", exp_res.peek_available, out_item.peek_available);
        check_field("peeked_number", exp_res.peeked_number, out_item.peeked_number);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Right after reset the FIFO is empty: reads and peeks must fail, unknown
  // codes must be refused, and the cursor operations succeed without effect.
  task automatic test_empty_after_reset();
    send_req(REQ_READ, 8'h00, 1'b0);
    send_req(REQ_PEEK, 8'hFF, 1'b1);
    send_req(REQ_BAD_LO, 8'h81, 1'b0);
    send_req(REQ_BAD_HI, 8'h7E, 1'b1);
    send_req(REQ_RESET_PEEK, 8'h00, 1'b0);
    send_req(REQ_DROP_PEEK, 8'h00, 1'b0);
  endtask

  // Byte extremes through the store, peeking ahead, rewinding the peek
  // cursor, dropping what was peeked and reading behind it.
  task automatic test_cursor_ops();
    send_req(REQ_WRITE, 8'h00, 1'b0);
    send_req(REQ_WRITE, 8'hFF, 1'b1);
    send_req(REQ_WRITE, 8'hA5, 1'b0);
    send_req(REQ_WRITE, 8'h5A, 1'b0);
    send_req(REQ_PEEK, 8'h00, 1'b0);
    send_req(REQ_PEEK, 8'h00, 1'b0);
    send_req(REQ_RESET_PEEK, 8'h00, 1'b0);
    send_req(REQ_PEEK, 8'h00, 1'b0);
    send_req(REQ_DROP_PEEK, 8'h00, 1'b0);
    send_req(REQ_READ, 8'h00, 1'b0);
  endtask

  // A size of zero is taken as a one-entry ring: one write fills it, a
  // second write fails, and reading past empty fails.
  task automatic test_ring_size_limits();
    set_ring_size(9'd0);
    send_req(REQ_INIT, 8'h00, 1'b0);
    send_req(REQ_WRITE, 8'h3C, 1'b0);
    send_req(REQ_WRITE, 8'hC3, 1'b0);
    send_req(REQ_READ, 8'h00, 1'b0);
    send_req(REQ_READ, 8'h00, 1'b0);
  endtask

  // An oversized register value means the whole store. Init with the full
  // flag marks every entry as held; only entries written earlier are read.
  task automatic test_init_full();
    set_ring_size(9'h1FF);
    send_req(REQ_INIT, 8'h00, 1'b1);
    send_req(REQ_WRITE, 8'h11, 1'b0);
    send_req(REQ_READ, 8'h00, 1'b0);
    send_req(REQ_PEEK, 8'h00, 1'b0);
  endtask

  // The ring shrinks under a FIFO that still holds data and no init follows.
  // The head sits beyond the new ring, so the next read wraps it to zero.
  task automatic test_shrunk_ring();
    set_ring_size(9'd1);
    send_req(REQ_WRITE, 8'h22, 1'b0);
    send_req(REQ_READ, 8'h00, 1'b0);
    send_req(REQ_PEEK, 8'h00, 1'b0);
  endtask

  // One stretch of random traffic at a given ring size and idling rate.
  // Writes take write_pct of the requests and the rest is spread over the
  // other operations. A read or peek that would land on a never-written
  // entry is turned into a write instead.
  task automatic random_phase(input logic [8:0] ring_size, input int pace,
                              input int count, input int write_pct,
                              input bit reinit);
    req_code_t code;
    int        pick;
    set_ring_size(ring_size);
    idle_pct = pace;
    if (reinit) begin
      send_req(REQ_INIT, 8'($urandom), 1'b0);
    end
    repeat (count) begin
      if ($urandom_range(99) < write_pct) begin
        code = REQ_WRITE;
      end else begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          code = REQ_READ;
        end else if (pick < 60) begin
          code = REQ_PEEK;
        end else if (pick < 72) begin
          code = REQ_RESET_PEEK;
        end else if (pick < 84) begin
          code = REQ_DROP_PEEK;
        end else if (pick < 92) begin
          code = REQ_INIT;
        end else begin
          code = $urandom_range(1) ? REQ_BAD_HI : REQ_BAD_LO;
        end
      end
      if (code == REQ_READ && held != 0 && !byte_written[head_ptr]) begin
        code = REQ_WRITE;
      end
      if (code == REQ_PEEK && peek_rem != 0 && !byte_written[peek_ptr]) begin
        code = REQ_WRITE;
      end
      // Full inits are kept rare since they park the ring on unwritten bytes.
      send_req(code, 8'($urandom),
               (code == REQ_INIT) ? ($urandom_range(3) == 0) : 1'($urandom));
    end
    idle_pct = 0;
  endtask

  // Random traffic over several ring sizes and idling rates. Each size change
  // waits for the block to go quiet; some phases keep the old cursors and
  // counts so that a resize without init is exercised too.
  task automatic test_random_traffic();
    random_phase(9'd256, 0, 130, 60, 1'b1);
    random_phase(9'd3, 64, 110, 40, 1'($urandom));
    random_phase(9'd1, 10, 60, 45, 1'($urandom));
    random_phase(9'($urandom_range(2, 32)), 64, 110, 45, 1'($urandom));
    random_phase(9'd300, 10, 120, 50, 1'($urandom));
    random_phase(9'd7, 0, 60, 40, 1'($urandom));
    random_phase(9'd2, 64, 60, 45, 1'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_after_reset();
    test_cursor_ops();
    test_ring_size_limits();
    test_init_full();
    test_shrunk_ring();
    test_random_traffic();
    // Every result is due in the cycle after its request; the extra settling
    // cycles catch any stray strobe.
    wait_results_drained(5);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bfp_pkg.sv
rtl/bfp_ram.sv
rtl/bfp_ctrl.sv
rtl/byte_ring_fifo_with_peek.sv
tb/testbench.sv
